/* sv/jst_pkg.sv */
// shared types and constants of the json stream tokenizer
package jst_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SCNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W      = $clog2(STACK_DEPTH);
    localparam int TOK_W       = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [TOK_W-1:0] MAX_LEN_RESET = TOK_W'(64);

    typedef enum logic [3:0] {
        EV_OBJBEGIN = 4'd0,
        EV_OBJEND   = 4'd1,
        EV_ARRBEGIN = 4'd2,
        EV_ARREND   = 4'd3,
        EV_TOKBYTE  = 4'd4,
        EV_NAME     = 4'd5,
        EV_STRING   = 4'd6,
        EV_NUMBER   = 4'd7,
        EV_KEYWORD  = 4'd8,
        EV_ERROR    = 4'd9
    } event_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       failed;
    } evt_t;

    // up to two events produced by one accepted byte
    typedef struct packed {
        logic [1:0]      n;
        evt_t [1:0]      evs;
    } push_t;

endpackage

/* sv/jst_front.sv */
// parser front end: byte classification, state machine and return stack
module jst_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic [7:0]               ch,
    input  logic                     cfg_we,
    input  logic [jst_pkg::TOK_W-1:0] cfg_len,
    output jst_pkg::push_t           push
);
    import jst_pkg::*;

    typedef enum logic [18:0] {
        S_ERR          = 19'h00001,
        S_FIRST_WHOLE  = 19'h00002,
        S_WHOLE        = 19'h00004,
        S_FIRST_FRAC   = 19'h00008,
        S_FRAC         = 19'h00010,
        S_EXP          = 19'h00020,
        S_FIRST_EXPDIG = 19'h00040,
        S_EXPDIG       = 19'h00080,
        S_KEYWORD      = 19'h00100,
        S_ESCAPED      = 19'h00200,
        S_UNICODE      = 19'h00400,
        S_STRING       = 19'h00800,
        S_OBJ_OR_ARR   = 19'h01000,
        S_NAME         = 19'h02000,
        S_MEMBER_SEP   = 19'h04000,
        S_NEXT_MEMBER  = 19'h08000,
        S_NEXT_ELEMENT = 19'h10000,
        S_VALUE        = 19'h20000,
        S_COMPLETE     = 19'h40000
    } state_t;

    localparam logic [1:0] RET_COMPLETE = 2'd0;
    localparam logic [1:0] RET_MEMBER   = 2'd1;
    localparam logic [1:0] RET_ELEMENT  = 2'd2;
    localparam logic [1:0] RET_BAD      = 2'd3;

    typedef struct packed {
        state_t             ps;
        state_t             avs;
        logic [SCNT_W-1:0]  scnt;
        logic               member;
        logic [2:0]         hexc;
        logic [TOK_W-1:0]   tlen;
        logic               psh;
        logic [SIDX_W-1:0]  psh_idx;
        logic [1:0]         psh_code;
        logic               again;
        logic [1:0]         n;
        evt_t [1:0]         evs;
    } st_t;

    state_t            ps_reg, ps_next;
    state_t            avs_reg, avs_next;
    logic [SCNT_W-1:0] scnt_reg, scnt_next;
    logic              member_reg, member_next;
    logic [2:0]        hexc_reg, hexc_next;
    logic [TOK_W-1:0]  tlen_reg, tlen_next;
    logic [TOK_W-1:0]  max_len_reg;
    logic [1:0]        stack_mem [STACK_DEPTH];
    logic [SCNT_W-1:0] scnt_m1;
    logic [1:0]        pop_code;
    st_t               s;

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return c inside {8'h20, 8'h0d, 8'h0a, 8'h09};
    endfunction

    // states past the string states skip whitespace
    function automatic logic is_struct(state_t p);
        return p inside {S_OBJ_OR_ARR, S_NAME, S_MEMBER_SEP, S_NEXT_MEMBER,
                         S_NEXT_ELEMENT, S_VALUE, S_COMPLETE};
    endfunction

    function automatic st_t emit(st_t x, event_t ev, logic [7:0] b);
        st_t y;
        y = x;
        if (y.n < 2'd2) begin
            y.evs[y.n[0]].ev     = ev;
            y.evs[y.n[0]].data   = b;
            y.evs[y.n[0]].last   = 1'b0;
            y.evs[y.n[0]].done   = (y.ps == S_COMPLETE) || (y.ps == S_ERR);
            y.evs[y.n[0]].failed = (y.ps == S_ERR);
            y.n = y.n + 2'd1;
        end
        return y;
    endfunction

    function automatic st_t fail(st_t x);
        st_t y;
        y = x;
        y.ps   = S_ERR;
        y.scnt = '0;
        return emit(y, EV_ERROR, 8'h00);
    endfunction

    function automatic logic [1:0] code_of(state_t p);
        case (p)
            S_COMPLETE:     return RET_COMPLETE;
            S_NEXT_MEMBER:  return RET_MEMBER;
            S_NEXT_ELEMENT: return RET_ELEMENT;
            default:        return RET_BAD;
        endcase
    endfunction

    function automatic st_t push_ret(st_t x, state_t p);
        st_t y;
        y = x;
        if (y.scnt >= SCNT_W'(STACK_DEPTH)) begin
            y = fail(y);
        end
        else begin
            y.psh      = 1'b1;
            y.psh_idx  = y.scnt[SIDX_W-1:0];
            y.psh_code = code_of(p);
            y.scnt     = y.scnt + 1'b1;
        end
        return y;
    endfunction

    function automatic st_t close_cont(st_t x, event_t ev, logic [1:0] pc);
        st_t y;
        y = x;
        if (y.scnt == '0) begin
            y = fail(y);
        end
        else begin
            y.scnt = y.scnt - 1'b1;
            if (pc == RET_BAD) begin
                y = fail(y);
            end
            else begin
                y.ps = (pc == RET_COMPLETE) ? S_COMPLETE :
                       (pc == RET_MEMBER)   ? S_NEXT_MEMBER : S_NEXT_ELEMENT;
                y = emit(y, ev, 8'h00);
            end
        end
        return y;
    endfunction

    function automatic st_t append(st_t x, logic [7:0] c, logic [TOK_W-1:0] mx);
        st_t y;
        y = x;
        if (({1'b0, y.tlen} + 1'b1) < {1'b0, mx}) begin
            y.tlen = y.tlen + 1'b1;
            y = emit(y, EV_TOKBYTE, c);
        end
        else begin
            y = fail(y);
        end
        return y;
    endfunction

    function automatic st_t finish(st_t x, event_t ev);
        st_t y;
        y = emit(x, ev, 8'h00);
        y.again = 1'b1;
        if (is_struct(y.avs)) y.ps = y.avs;
        else y = fail(y);
        return y;
    endfunction

    function automatic st_t start_tok(st_t x, state_t p, logic [7:0] c, logic keep,
                                      logic [TOK_W-1:0] mx);
        st_t y;
        y = x;
        y.ps   = p;
        y.tlen = '0;
        if (keep) y = append(y, c, mx);
        return y;
    endfunction

    function automatic st_t process(st_t x, logic [7:0] c, logic [TOK_W-1:0] mx,
                                    logic [1:0] pc);
        st_t        y;
        state_t     ret;
        logic [7:0] d;
        y = x;
        y.again = 1'b0;
        ret = y.avs;
        d = 8'h00;
        if (!(is_struct(y.ps) && is_ws(c))) begin
            case (y.ps)
                S_ERR: ;
                S_COMPLETE: y = fail(y);
                S_OBJ_OR_ARR: begin
                    if (c == "{") begin
                        y.scnt = '0;
                        y = push_ret(y, S_COMPLETE);
                        y.ps = S_NAME;
                        y = emit(y, EV_OBJBEGIN, 8'h00);
                    end
                    else if (c == "[") begin
                        y.scnt = '0;
                        y = push_ret(y, S_COMPLETE);
                        y.avs = S_NEXT_ELEMENT;
                        y.ps  = S_VALUE;
                        y = emit(y, EV_ARRBEGIN, 8'h00);
                    end
                    else y = fail(y);
                end
                S_NAME: begin
                    if (c == "\"") begin
                        y.member = 1'b1;
                        y.avs    = S_MEMBER_SEP;
                        y = start_tok(y, S_STRING, c, 1'b0, mx);
                    end
                    else if (c == "}") y = close_cont(y, EV_OBJEND, pc);
                    else y = fail(y);
                end
                S_MEMBER_SEP: begin
                    if (c == ":") begin
                        y.avs = S_NEXT_MEMBER;
                        y.ps  = S_VALUE;
                    end
                    else y = fail(y);
                end
                S_NEXT_MEMBER: begin
                    if (c == ",") y.ps = S_NAME;
                    else if (c == "}") y = close_cont(y, EV_OBJEND, pc);
                    else y = fail(y);
                end
                S_NEXT_ELEMENT: begin
                    if (c == ",") begin
                        y.avs = S_NEXT_ELEMENT;
                        y.ps  = S_VALUE;
                    end
                    else if (c == "]") y = close_cont(y, EV_ARREND, pc);
                    else y = fail(y);
                end
                S_VALUE: begin
                    if (c == "{") begin
                        y.avs = S_ERR;
                        y.ps  = S_NAME;
                        y = emit(y, EV_OBJBEGIN, 8'h00);
                        y = push_ret(y, ret);
                    end
                    else if (c == "[") begin
                        y.avs = S_NEXT_ELEMENT;
                        y = emit(y, EV_ARRBEGIN, 8'h00);
                        y = push_ret(y, ret);
                    end
                    else if (c == "-" || c == "+") y = start_tok(y, S_FIRST_WHOLE, c, 1'b1, mx);
                    else if (is_digit(c)) y = start_tok(y, S_WHOLE, c, 1'b1, mx);
                    else if (c == "\"") begin
                        y.member = 1'b0;
                        y = start_tok(y, S_STRING, c, 1'b0, mx);
                    end
                    else if (is_alpha(c)) y = start_tok(y, S_KEYWORD, c, 1'b1, mx);
                    else if (c == "]") y = close_cont(y, EV_ARREND, pc);
                end
                S_KEYWORD: begin
                    if (is_alpha(c)) y = append(y, c, mx);
                    else y = finish(y, EV_KEYWORD);
                end
                S_STRING: begin
                    if (c == "\\") y.ps = S_ESCAPED;
                    else if (c == "\"") y = finish(y, y.member ? EV_NAME : EV_STRING);
                    else y = append(y, c, mx);
                    y.again = 1'b0;
                end
                S_ESCAPED: begin
                    case (c)
                        "\"":    d = "\"";
                        "\\":    d = "\\";
                        "/":     d = "/";
                        "b":     d = 8'h08;
                        "f":     d = 8'h0c;
                        "n":     d = 8'h0a;
                        "r":     d = 8'h0d;
                        "t":     d = 8'h09;
                        default: d = 8'h00;
                    endcase
                    if (c == "u") begin
                        y.ps   = S_UNICODE;
                        y.hexc = 3'd0;
                    end
                    else if (d == 8'h00) y = fail(y);
                    else begin
                        y.ps = S_STRING;
                        y = append(y, d, mx);
                    end
                end
                S_UNICODE: begin
                    y.hexc = y.hexc + 3'd1;
                    if (!is_hex(c)) y = fail(y);
                    else if (y.hexc >= 3'd4) begin
                        y.ps = S_STRING;
                        y = append(y, "?", mx);
                    end
                end
                S_FIRST_WHOLE: begin
                    if (is_digit(c)) begin
                        y.ps = S_WHOLE;
                        y = append(y, c, mx);
                    end
                    else y = fail(y);
                end
                S_WHOLE: begin
                    if (is_digit(c)) y = append(y, c, mx);
                    else if (c == "e" || c == "E") begin
                        y.ps = S_EXP;
                        y = append(y, c, mx);
                    end
                    else if (c == ".") begin
                        y.ps = S_FIRST_FRAC;
                        y = append(y, c, mx);
                    end
                    else y = finish(y, EV_NUMBER);
                end
                S_FIRST_FRAC: begin
                    if (is_digit(c)) begin
                        y.ps = S_FRAC;
                        y = append(y, c, mx);
                    end
                    else if (c == "e" || c == "E") y = fail(y);
                    else y = finish(y, EV_NUMBER);
                end
                S_FRAC: begin
                    if (is_digit(c)) y = append(y, c, mx);
                    else if (c == "e" || c == "E") begin
                        y.ps = S_EXP;
                        y = append(y, c, mx);
                    end
                    else y = finish(y, EV_NUMBER);
                end
                S_EXP: begin
                    if (c == "-" || c == "+") begin
                        y.ps = S_FIRST_EXPDIG;
                        y = append(y, c, mx);
                    end
                    else if (is_digit(c)) begin
                        y.ps = S_EXPDIG;
                        y = append(y, c, mx);
                    end
                    else y = finish(y, EV_NUMBER);
                end
                S_FIRST_EXPDIG, S_EXPDIG: begin
                    if (is_digit(c)) begin
                        y.ps = S_EXPDIG;
                        y = append(y, c, mx);
                    end
                    else y = finish(y, EV_NUMBER);
                end
                default: y = fail(y);
            endcase
        end
        return y;
    endfunction

    // only the top entry is ever read, and at most one pop per byte
    assign scnt_m1  = scnt_reg - 1'b1;
    assign pop_code = stack_mem[scnt_m1[SIDX_W-1:0]];

    always_comb
    begin
        s          = '0;
        s.ps       = ps_reg;
        s.avs      = avs_reg;
        s.scnt     = scnt_reg;
        s.member   = member_reg;
        s.hexc     = hexc_reg;
        s.tlen     = tlen_reg;
        if (ps_reg == S_ERR) begin
            s.n = 2'd0;
        end
        else if (ch == 8'h00) begin
            if (ps_reg != S_COMPLETE) s = fail(s);
        end
        else begin
            s = process(s, ch, max_len_reg, pop_code);
            // a byte that ends a number or keyword is looked at again
            if (s.again) s = process(s, ch, max_len_reg, pop_code);
        end
        if (s.n != 2'd0) s.evs[s.n[0] ^ 1'b1].last = 1'b1;

        ps_next     = s.ps;
        avs_next    = s.avs;
        scnt_next   = s.scnt;
        member_next = s.member;
        hexc_next   = s.hexc;
        tlen_next   = s.tlen;

        push.n   = fire ? s.n : 2'd0;
        push.evs = s.evs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ps_reg      <= S_OBJ_OR_ARR;
            avs_reg     <= S_ERR;
            scnt_reg    <= '0;
            member_reg  <= 1'b0;
            hexc_reg    <= 3'd0;
            tlen_reg    <= '0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else begin
            if (cfg_we) max_len_reg <= cfg_len;
            if (fire) begin
                ps_reg     <= ps_next;
                avs_reg    <= avs_next;
                scnt_reg   <= scnt_next;
                member_reg <= member_next;
                hexc_reg   <= hexc_next;
                tlen_reg   <= tlen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && s.psh) stack_mem[s.psh_idx] <= s.psh_code;
    end

`ifndef ASSERT_OFF
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (ps_reg == S_ERR) |-> (push.n == 2'd0))
        else $error("events produced in failed state");
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scnt_reg <= SCNT_W'(STACK_DEPTH))
        else $error("return stack count past depth");
`endif

endmodule

/* sv/jst_queue.sv */
// event queue between the parser and the output port
module jst_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  jst_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output jst_pkg::evt_t  head
);
    import jst_pkg::*;

    evt_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem[rp_reg];
    // room for the worst case of two events, independent of the output side
    assign room      = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign cnt_next  = cnt_reg + QCNT_W'(push.n) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wp_reg  <= wp_reg + QPTR_W'(push.n);
            rp_reg  <= rp_reg + QPTR_W'(pop);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0) mem[wp_reg] <= push.evs[0];
        if (push.n == 2'd2) mem[wp_reg + 1'b1] <= push.evs[1];
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("event queue overflow");
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2)))
        else $error("push into queue without room");
`endif

endmodule

/* sv/json_stream_tokenizer.sv */
// top level of the streaming json tokenizer
// Takes one byte of JSON text per transaction on ch (0 ends the text) and
// gives a stream of events; one byte is accepted every cycle, and a byte
// causes up to two events, which sit in a four-entry event queue drained at
// one event per cycle while out_ready is high, so the byte input stalls only
// when the queue has fewer than two free entries. Parse state, the 16-entry
// return stack and token length update as a byte is accepted. The user must
// write max_token_len (cfg channel, always ready) only while idle (unenforced).
module json_stream_tokenizer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                ch,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [jst_pkg::TOK_W-1:0] max_token_len,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [3:0]                event_res,
    output logic [7:0]                data_byte,
    output logic                      last,
    output logic                      done_res,
    output logic                      failed
);
    import jst_pkg::*;

    push_t push;
    evt_t  head;
    logic  room;
    logic  fire;

    assign in_ready  = room;
    assign fire      = in_valid && room;
    assign cfg_ready = 1'b1;

    jst_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .ch      (ch),
        .cfg_we  (cfg_valid),
        .cfg_len (max_token_len),
        .push    (push)
    );

    jst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign event_res = head.ev;
    assign data_byte = head.data;
    assign last      = head.last;
    assign done_res  = head.done;
    assign failed    = head.failed;

endmodule

/* test/json_stream_tokenizer_tb.sv */
// self-checking testbench for the streaming json tokenizer
module json_stream_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jst_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_N       = 31;

    typedef enum logic [4:0] {
        P_ERR, P_FIRST_WHOLE, P_WHOLE, P_FIRST_FRAC, P_FRAC, P_EXP, P_FIRST_EXPDIG,
        P_EXPDIG, P_KEYWORD, P_ESCAPED, P_UNICODE, P_STRING, P_OBJ_OR_ARR, P_NAME,
        P_MEMBER_SEP, P_NEXT_MEMBER, P_NEXT_ELEMENT, P_VALUE, P_COMPLETE
    } pstate_t;

    typedef enum logic [1:0] {RET_COMPLETE, RET_MEMBER, RET_ELEMENT, RET_BAD} ret_t;

    typedef struct {
        logic [7:0] b;
        bit         chk;
        event_t     ev;
        logic [7:0] d;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       ch = 8'h00;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TOK_W-1:0] max_token_len = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [3:0]       event_res;
    logic [7:0]       data_byte;
    logic             last;
    logic             done_res;
    logic             failed;

    json_stream_tokenizer uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .ch(ch),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_token_len(max_token_len),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_res(event_res), .data_byte(data_byte), .last(last),
        .done_res(done_res), .failed(failed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // directed opening: a top array holding an object with an escaped name and a
    // signed exponent number, an ignored byte, a keyword and an empty array
    dir_row_t dir_tab [DIR_N] = '{
        '{"[",   1'b1, EV_ARRBEGIN, 8'h00},
        '{"{",   1'b1, EV_OBJBEGIN, 8'h00},
        '{8'h22, 1'b0, EV_ERROR,    8'h00},
        '{8'hFF, 1'b1, EV_TOKBYTE,  8'hFF},
        '{8'h5C, 1'b0, EV_ERROR,    8'h00},
        '{"b",   1'b1, EV_TOKBYTE,  8'h08},
        '{8'h5C, 1'b0, EV_ERROR,    8'h00},
        '{"u",   1'b0, EV_ERROR,    8'h00},
        '{"0",   1'b0, EV_ERROR,    8'h00},
        '{"F",   1'b0, EV_ERROR,    8'h00},
        '{"a",   1'b0, EV_ERROR,    8'h00},
        '{"9",   1'b1, EV_TOKBYTE,  "?"},
        '{8'h22, 1'b1, EV_NAME,     8'h00},
        '{":",   1'b0, EV_ERROR,    8'h00},
        '{"-",   1'b1, EV_TOKBYTE,  "-"},
        '{"1",   1'b0, EV_ERROR,    8'h00},
        '{"e",   1'b0, EV_ERROR,    8'h00},
        '{"+",   1'b0, EV_ERROR,    8'h00},
        '{"3",   1'b0, EV_ERROR,    8'h00},
        '{"}",   1'b1, EV_NUMBER,   8'h00},
        '{",",   1'b0, EV_ERROR,    8'h00},
        '{"#",   1'b0, EV_ERROR,    8'h00},
        '{"t",   1'b0, EV_ERROR,    8'h00},
        '{"r",   1'b0, EV_ERROR,    8'h00},
        '{"u",   1'b0, EV_ERROR,    8'h00},
        '{"e",   1'b0, EV_ERROR,    8'h00},
        '{" ",   1'b1, EV_KEYWORD,  8'h00},
        '{",",   1'b0, EV_ERROR,    8'h00},
        '{"[",   1'b1, EV_ARRBEGIN, 8'h00},
        '{"]",   1'b1, EV_ARREND,   8'h00},
        '{",",   1'b0, EV_ERROR,    8'h00}
    };

    // tokenizer state as predicted
    pstate_t          ps = P_OBJ_OR_ARR;
    pstate_t          after_val = P_ERR;
    ret_t             ret_stack [STACK_DEPTH];
    int               ret_cnt = 0;
    bit               in_key_str = 1'b0;
    int               hex_cnt = 0;
    int               tok_len = 0;
    int               tok_max = 64;
    evt_t             byte_evs[$];
    evt_t             pending_evs[$];

    int               errors = 0;
    int               n_accepted = 0;
    int               snd_idle_pct = 0;
    int               rcv_idle_pct = 0;
    logic             hold_go = 1'b0;
    logic             hold_used;
    int               hold_cnt;
    int               stall_cnt;
    int               tok_lim = 63;
    logic [7:0]       text_q[$];

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void add_event(input event_t ev, input logic [7:0] b);
        evt_t e;
        if (byte_evs.size() >= 2)
            return;
        e.ev = ev;
        e.data = b;
        e.last = 1'b0;
        e.done = (ps == P_COMPLETE || ps == P_ERR);
        e.failed = (ps == P_ERR);
        byte_evs.push_back(e);
    endfunction

    function automatic void go_failed();
        ps = P_ERR;
        ret_cnt = 0;
        add_event(EV_ERROR, 8'h00);
    endfunction

    function automatic void push_return(input pstate_t s);
        if (ret_cnt >= STACK_DEPTH)
        begin
            go_failed();
            return;
        end
        ret_stack[ret_cnt] = (s == P_COMPLETE) ? RET_COMPLETE :
                             (s == P_NEXT_MEMBER) ? RET_MEMBER :
                             (s == P_NEXT_ELEMENT) ? RET_ELEMENT : RET_BAD;
        ret_cnt++;
    endfunction

    function automatic void pop_close(input event_t ev);
        ret_t r;
        if (ret_cnt == 0)
        begin
            go_failed();
            return;
        end
        ret_cnt--;
        r = ret_stack[ret_cnt];
        if (r == RET_BAD)
        begin
            go_failed();
            return;
        end
        ps = (r == RET_COMPLETE) ? P_COMPLETE : (r == RET_MEMBER) ? P_NEXT_MEMBER : P_NEXT_ELEMENT;
        add_event(ev, 8'h00);
    endfunction

    function automatic void add_tok_byte(input logic [7:0] c);
        if (tok_len + 1 < tok_max)
        begin
            tok_len++;
            add_event(EV_TOKBYTE, c);
        end
        else
            go_failed();
    endfunction

    function automatic void end_token(input event_t ev);
        add_event(ev, 8'h00);
        if (after_val > P_STRING && after_val <= P_COMPLETE)
            ps = after_val;
        else
            go_failed();
    endfunction

    function automatic void begin_token(input pstate_t s, input logic [7:0] c, input bit keep);
        ps = s;
        tok_len = 0;
        if (keep)
            add_tok_byte(c);
    endfunction

    // one pass over a byte; returns 1 when the byte has to be looked at again
    function automatic bit scan_byte(input logic [7:0] c);
        pstate_t r;
        bit is_ws;
        logic [7:0] d;
        is_ws = (c == " " || c == 8'h0D || c == 8'h0A || c == 8'h09);
        if (ps > P_STRING && is_ws)
            return 1'b0;
        case (ps)
            P_ERR: ;
            P_COMPLETE: go_failed();
            P_OBJ_OR_ARR:
                if (c == "{")
                begin
                    ret_cnt = 0;
                    push_return(P_COMPLETE);
                    ps = P_NAME;
                    add_event(EV_OBJBEGIN, 8'h00);
                end
                else if (c == "[")
                begin
                    ret_cnt = 0;
                    push_return(P_COMPLETE);
                    after_val = P_NEXT_ELEMENT;
                    ps = P_VALUE;
                    add_event(EV_ARRBEGIN, 8'h00);
                end
                else
                    go_failed();
            P_NAME:
                if (c == 8'h22)
                begin
                    in_key_str = 1'b1;
                    after_val = P_MEMBER_SEP;
                    begin_token(P_STRING, c, 1'b0);
                end
                else if (c == "}")
                    pop_close(EV_OBJEND);
                else
                    go_failed();
            P_MEMBER_SEP:
                if (c == ":")
                begin
                    after_val = P_NEXT_MEMBER;
                    ps = P_VALUE;
                end
                else
                    go_failed();
            P_NEXT_MEMBER:
                if (c == ",")
                    ps = P_NAME;
                else if (c == "}")
                    pop_close(EV_OBJEND);
                else
                    go_failed();
            P_NEXT_ELEMENT:
                if (c == ",")
                begin
                    after_val = P_NEXT_ELEMENT;
                    ps = P_VALUE;
                end
                else if (c == "]")
                    pop_close(EV_ARREND);
                else
                    go_failed();
            P_VALUE:
                if (c == "{")
                begin
                    r = after_val;
                    after_val = P_ERR;
                    ps = P_NAME;
                    add_event(EV_OBJBEGIN, 8'h00);
                    push_return(r);
                end
                else if (c == "[")
                begin
                    r = after_val;
                    after_val = P_NEXT_ELEMENT;
                    add_event(EV_ARRBEGIN, 8'h00);
                    push_return(r);
                end
                else if (c == "-" || c == "+")
                    begin_token(P_FIRST_WHOLE, c, 1'b1);
                else if (is_digit(c))
                    begin_token(P_WHOLE, c, 1'b1);
                else if (c == 8'h22)
                begin
                    in_key_str = 1'b0;
                    begin_token(P_STRING, c, 1'b0);
                end
                else if (is_alpha(c))
                    begin_token(P_KEYWORD, c, 1'b1);
                else if (c == "]")
                    pop_close(EV_ARREND);
            P_KEYWORD:
            begin
                if (is_alpha(c))
                begin
                    add_tok_byte(c);
                    return 1'b0;
                end
                end_token(EV_KEYWORD);
                return 1'b1;
            end
            P_STRING:
                if (c == 8'h5C)
                    ps = P_ESCAPED;
                else if (c == 8'h22)
                    end_token(in_key_str ? EV_NAME : EV_STRING);
                else
                    add_tok_byte(c);
            P_ESCAPED:
            begin
                case (c)
                    8'h22, 8'h5C, "/": d = c;
                    "b": d = 8'h08;
                    "f": d = 8'h0C;
                    "n": d = 8'h0A;
                    "r": d = 8'h0D;
                    "t": d = 8'h09;
                    "u":
                    begin
                        ps = P_UNICODE;
                        hex_cnt = 0;
                        return 1'b0;
                    end
                    default:
                    begin
                        go_failed();
                        return 1'b0;
                    end
                endcase
                ps = P_STRING;
                add_tok_byte(d);
            end
            P_UNICODE:
            begin
                hex_cnt = (hex_cnt + 1) & 7;
                if (!(is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
                    go_failed();
                else if (hex_cnt >= 4)
                begin
                    ps = P_STRING;
                    add_tok_byte("?");
                end
            end
            P_FIRST_WHOLE:
                if (is_digit(c))
                begin
                    ps = P_WHOLE;
                    add_tok_byte(c);
                end
                else
                    go_failed();
            P_WHOLE, P_FRAC:
            begin
                if (is_digit(c))
                    add_tok_byte(c);
                else if (c == "e" || c == "E")
                begin
                    ps = P_EXP;
                    add_tok_byte(c);
                end
                else if (c == "." && ps == P_WHOLE)
                begin
                    ps = P_FIRST_FRAC;
                    add_tok_byte(c);
                end
                else
                begin
                    end_token(EV_NUMBER);
                    return 1'b1;
                end
            end
            P_FIRST_FRAC:
            begin
                if (is_digit(c))
                begin
                    ps = P_FRAC;
                    add_tok_byte(c);
                end
                else if (c == "e" || c == "E")
                    go_failed();
                else
                begin
                    end_token(EV_NUMBER);
                    return 1'b1;
                end
            end
            P_EXP:
            begin
                if (c == "-" || c == "+")
                begin
                    ps = P_FIRST_EXPDIG;
                    add_tok_byte(c);
                end
                else if (is_digit(c))
                begin
                    ps = P_EXPDIG;
                    add_tok_byte(c);
                end
                else
                begin
                    end_token(EV_NUMBER);
                    return 1'b1;
                end
            end
            P_FIRST_EXPDIG, P_EXPDIG:
            begin
                if (is_digit(c))
                begin
                    ps = P_EXPDIG;
                    add_tok_byte(c);
                end
                else
                begin
                    end_token(EV_NUMBER);
                    return 1'b1;
                end
            end
            default: go_failed();
        endcase
        return 1'b0;
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c);
        byte_evs = {};
        if (ps == P_ERR)
            return;
        if (c == 8'h00)
        begin
            if (ps != P_COMPLETE)
                go_failed();
        end
        else if (scan_byte(c))
            void'(scan_byte(c));
        if (byte_evs.size() > 0)
            byte_evs[byte_evs.size()-1].last = 1'b1;
        foreach (byte_evs[i])
            pending_evs.push_back(byte_evs[i]);
    endfunction

    // ---- text generation ----

    function automatic void add_ws();
        logic [7:0] ws_set [4] = '{" ", 8'h0D, 8'h0A, 8'h09};
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) text_q.push_back(ws_set[$urandom_range(0, 3)]);
    endfunction

    // bytes that the value position skips over
    function automatic void add_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 2))
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (is_digit(b) || is_alpha(b) || b == "-" || b == "+" || b == 8'h22 ||
                   b == "{" || b == "[" || b == "]" || b == " " || b == 8'h0D ||
                   b == 8'h0A || b == 8'h09);
            text_q.push_back(b);
        end
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic void gen_string(input int most);
        logic [7:0] esc_set [8] = '{8'h22, 8'h5C, "/", "b", "f", "n", "r", "t"};
        logic [7:0] hex_set [22] = '{"0","1","2","3","4","5","6","7","8","9","a","b","c",
                                     "d","e","f","A","B","C","D","E","F"};
        logic [7:0] b;
        int r;
        text_q.push_back(8'h22);
        repeat ($urandom_range(0, tok_lim < most ? tok_lim : most))
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                do
                    b = 8'($urandom_range(1, 255));
                while (b == 8'h22 || b == 8'h5C);
                text_q.push_back(b);
            end
            else if (r < 88)
            begin
                text_q.push_back(8'h5C);
                text_q.push_back(esc_set[$urandom_range(0, 7)]);
            end
            else
            begin
                text_q.push_back(8'h5C);
                text_q.push_back("u");
                repeat (4) text_q.push_back(hex_set[$urandom_range(0, 21)]);
            end
        end
        text_q.push_back(8'h22);
    endfunction

    function automatic void gen_number();
        logic [7:0] t[$];
        int nd;
        bit exp_ok;
        exp_ok = 1'b1;
        if ($urandom_range(0, 3) == 0)
            t.push_back($urandom_range(0, 1) ? "-" : "+");
        repeat ($urandom_range(1, 3)) t.push_back(rand_digit());
        if ($urandom_range(0, 2) == 0)
        begin
            t.push_back(".");
            nd = $urandom_range(0, 3);
            exp_ok = (nd != 0);
            repeat (nd) t.push_back(rand_digit());
        end
        if (exp_ok && $urandom_range(0, 2) == 0)
        begin
            t.push_back($urandom_range(0, 1) ? "e" : "E");
            if ($urandom_range(0, 1))
                t.push_back($urandom_range(0, 1) ? "-" : "+");
            repeat ($urandom_range(0, 2)) t.push_back(rand_digit());
        end
        if (t.size() > tok_lim)
        begin
            t = {};
            repeat ($urandom_range(1, tok_lim < 4 ? tok_lim : 4)) t.push_back(rand_digit());
        end
        text_q = {text_q, t};
    endfunction

    function automatic void gen_value(input int depth);
        int r;
        int n;
        if ($urandom_range(0, 9) == 0)
            add_noise();
        r = $urandom_range(0, 99);
        if (depth < STACK_DEPTH && r < (depth < 4 ? 20 : 6))
        begin
            n = $urandom_range(0, 3);
            if ($urandom_range(0, 1))
            begin
                text_q.push_back("[");
                add_ws();
                for (int i = 0; i < n; i++)
                begin
                    if (i != 0)
                        text_q.push_back(",");
                    gen_value(depth + 1);
                end
                text_q.push_back("]");
            end
            else
            begin
                text_q.push_back("{");
                for (int i = 0; i < n; i++)
                begin
                    if (i != 0)
                        text_q.push_back(",");
                    add_ws();
                    gen_string(4);
                    add_ws();
                    text_q.push_back(":");
                    add_ws();
                    gen_value(depth + 1);
                end
                text_q.push_back("}");
            end
        end
        else if (tok_lim == 0 || r < 45)
            gen_string(8);
        else if (r < 80)
            gen_number();
        else
            repeat ($urandom_range(1, tok_lim < 6 ? tok_lim : 6))
                text_q.push_back(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
                                                         : "A" + $urandom_range(0, 25)));
        add_ws();
    endfunction

    // elements of the top array, each followed by a comma
    function automatic void gen_elements(input int count);
        while (text_q.size() < count)
        begin
            gen_value(1);
            text_q.push_back(",");
            add_ws();
        end
    endfunction

    // ---- drivers ----

    // in_ready is looked at mid-cycle, where it holds the value seen by the next edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= b;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i]);
        in_valid <= 1'b0;
        text_q = {};
    endtask

    task automatic wait_idle();
        while (pending_evs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max_len(input int v);
        cfg_valid <= 1'b1;
        max_token_len <= TOK_W'(v);
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        tok_lim = v - 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_go && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // ---- monitors ----

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            tok_max = max_token_len;
        if (rst_n && in_valid && in_ready)
        begin
            tokenize_byte(ch);
            if (n_accepted < DIR_N && dir_tab[n_accepted].chk)
            begin
                if (byte_evs.size() == 0)
                begin
                    $display("%0t: opening byte %0d: expected event %0d data %02h, actual none",
                             $time, n_accepted, dir_tab[n_accepted].ev, dir_tab[n_accepted].d);
                    errors++;
                end
                else if (byte_evs[0].ev != dir_tab[n_accepted].ev ||
                         byte_evs[0].data != dir_tab[n_accepted].d)
                begin
                    $display("%0t: opening byte %0d: expected event %0d data %02h, actual %0d %02h",
                             $time, n_accepted, dir_tab[n_accepted].ev, dir_tab[n_accepted].d,
                             byte_evs[0].ev, byte_evs[0].data);
                    errors++;
                end
            end
            n_accepted++;
        end
    end

    always @(posedge clk)
    begin
        evt_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_evs.size() == 0)
            begin
                $display("%0t: unexpected event %0d data %02h", $time, event_res, data_byte);
                errors++;
            end
            else
            begin
                e = pending_evs.pop_front();
                if (event_res != e.ev)
                begin
                    $display("%0t: event expected %0d actual %0d", $time, e.ev, event_res);
                    errors++;
                end
                if (data_byte != e.data)
                begin
                    $display("%0t: data_byte expected %02h actual %02h", $time, e.data, data_byte);
                    errors++;
                end
                if (last != e.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, e.last, last);
                    errors++;
                end
                if (done_res != e.done)
                begin
                    $display("%0t: done_res expected %0b actual %0b", $time, e.done, done_res);
                    errors++;
                end
                if (failed != e.failed)
                begin
                    $display("%0t: failed expected %0b actual %0b", $time, e.failed, failed);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    // ---- test sequence ----

    initial
    begin
        int kind;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver mostly stalls
        snd_idle_pct = 20;
        rcv_idle_pct <= 81;
        foreach (dir_tab[i])
            text_q.push_back(dir_tab[i].b);
        gen_elements(550);
        send_text();
        wait_idle();

        // widest token store of the run, roles of the two sides swapped
        write_max_len(4096);
        snd_idle_pct = 81;
        rcv_idle_pct <= 20;
        gen_string(300);
        text_q.push_back(",");
        gen_elements(600);
        send_text();
        wait_idle();

        // no token content allowed at all
        write_max_len(1);
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        gen_elements(150);
        send_text();
        wait_idle();

        // tiny store; the receiver holds off long enough to back up the input
        write_max_len(3);
        hold_go <= 1'b1;
        gen_elements(400);

        // the text ends in one of the ways the tokenizer fails
        kind = $urandom_range(0, 4);
        case (kind)
            0:
            begin
                text_q.push_back("]");
                text_q.push_back(8'h00);
                text_q.push_back(" ");
                text_q.push_back("1");
            end
            1: text_q.push_back(8'h00);
            2: text_q = {text_q, 8'h22, 8'h5C, "q"};
            3:
            begin
                text_q.push_back(8'h22);
                repeat (tok_lim + 1) text_q.push_back("a");
            end
            default: repeat (STACK_DEPTH) text_q.push_back("[");
        endcase
        // all of this is ignored once failed
        repeat (20) text_q.push_back(8'($urandom_range(0, 255)));
        send_text();
        wait_idle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
sv/jst_pkg.sv
sv/jst_front.sv
sv/jst_queue.sv
sv/json_stream_tokenizer.sv
test/json_stream_tokenizer_tb.sv
